/* hw/rtl/double_ended_queue_macros.svh */
// Assertion macros shared by the deque controller and datapath.
// Defining ASSERT_OFF turns every check into an empty statement.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF
// Concurrent check on a named clock and active-low reset.
`define DEQ_ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error(msg);
// Concurrent check on the block clock and reset.
`define DEQ_ASSERT(lbl, prop, msg) `DEQ_ASSERT_CLK(lbl, clk, arst_n, prop, msg)
`else
`define DEQ_ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop, msg)
`define DEQ_ASSERT(lbl, prop, msg)
`endif

`endif

/* hw/rtl/deq_pkg.sv */
// Shared types for the double-ended queue: opcodes, status codes and the
// controller-to-datapath command bundle. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

	typedef enum logic [3:0] {
		OP_PUSH_BACK  = 4'd0,
		OP_PUSH_FRONT = 4'd1,
		OP_POP_BACK   = 4'd2,
		OP_POP_FRONT  = 4'd3,
		OP_PEEK_BACK  = 4'd4,
		OP_PEEK_FRONT = 4'd5,
		OP_WRITE_BACK = 4'd6,
		OP_WRITE_FRONT = 4'd7,
		OP_CLEAR      = 4'd8
	} deq_op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} deq_status_t;

	typedef struct packed {
		logic load;
		logic exec;
	} deq_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/deq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/deq_ctrl.sv */
// Sequencer for the deque: takes a transfer, runs the execute state and
// then presents the result for one cycle. Depends on deq_pkg and the macros.
`timescale 1ns / 1ps
`default_nettype none
`include "double_ended_queue_macros.svh"

module deq_ctrl (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	output logic            done,
	output deq_pkg::deq_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESP
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;
	logic   accept;

	assign accept = start && !busy_q;

	// The result cycle only reads result registers, so a new transfer may
	// be taken while it is shown.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					done_q <= 1'b0;
					if (accept) begin
						state_q <= S_EXEC;
						busy_q  <= 1'b1;
					end
				end
				S_EXEC: begin
					state_q <= S_RESP;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				S_RESP: begin
					done_q <= 1'b0;
					if (accept) begin
						state_q <= S_EXEC;
						busy_q  <= 1'b1;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	assign cmd.load = accept;
	assign cmd.exec = (state_q == S_EXEC);
	assign busy     = busy_q;
	assign done     = done_q;

	`DEQ_ASSERT(a_done_single, done_q |=> !done_q, "result strobe held for two cycles")
	`DEQ_ASSERT(a_accept_busy, accept |=> (busy_q && cmd.exec), "accepted transfer did not execute")
	`DEQ_ASSERT(a_exec_done, cmd.exec |=> done_q, "execute cycle not followed by result")

endmodule

`default_nettype wire

/* hw/rtl/deq_datapath.sv */
// Deque datapath: front pointer, word count, slot memory and result registers.
// Depends on deq_pkg, deq_ram and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "double_ended_queue_macros.svh"

module deq_datapath #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire deq_pkg::deq_cmd_t             cmd,
	input  wire logic [3:0]                    opcode,
	input  wire logic signed [DATA_WIDTH-1:0]  value,
	output logic signed [DATA_WIDTH-1:0]       data,
	output logic [1:0]                         status,
	output logic [$clog2(DEPTH+1)-1:0]         count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW:0]   DEPTH_W    = (AW + 1)'(DEPTH);
	localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	logic [3:0]             op_q;
	logic [DATA_WIDTH-1:0]  value_q;
	logic [AW-1:0]          front_q;
	logic [CW-1:0]          count_q;
	deq_pkg::deq_status_t   status_q;
	logic                   rd_sel_q;

	logic [AW:0]            back_sum;
	logic [AW:0]            tail_sum;
	logic [AW-1:0]          back_slot;
	logic [AW-1:0]          tail_slot;
	logic [AW-1:0]          front_dec;
	logic [AW-1:0]          front_inc;
	logic                   is_empty;
	logic                   is_full;

	logic [AW-1:0]          front_n;
	logic [CW-1:0]          count_n;
	deq_pkg::deq_status_t   status_n;
	logic                   rd_sel_n;
	logic                   we;
	logic                   re;
	logic [AW-1:0]          addr;
	logic [DATA_WIDTH-1:0]  rdata;

	// Back word sits at front + count - 1, the next back slot at front + count,
	// both taken modulo the depth with one compare and subtract.
	assign back_sum  = {1'b0, front_q} + (AW + 1)'(count_q) - (AW + 1)'(1);
	assign tail_sum  = {1'b0, front_q} + (AW + 1)'(count_q);
	assign back_slot = (back_sum >= DEPTH_W) ? AW'(back_sum - DEPTH_W) : AW'(back_sum);
	assign tail_slot = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : AW'(tail_sum);
	assign front_dec = (front_q == '0) ? LAST_SLOT : front_q - AW'(1);
	assign front_inc = (front_q == LAST_SLOT) ? '0 : front_q + AW'(1);
	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q == FULL_COUNT);

	always_comb begin
		front_n  = front_q;
		count_n  = count_q;
		status_n = deq_pkg::ST_OK;
		rd_sel_n = 1'b0;
		we       = 1'b0;
		re       = 1'b0;
		addr     = front_q;
		case (op_q)
			deq_pkg::OP_PUSH_BACK: begin
				if (is_full) begin
					status_n = deq_pkg::ST_FULL;
				end else begin
					we      = 1'b1;
					addr    = tail_slot;
					count_n = count_q + CW'(1);
				end
			end
			deq_pkg::OP_PUSH_FRONT: begin
				if (is_full) begin
					status_n = deq_pkg::ST_FULL;
				end else begin
					we      = 1'b1;
					addr    = front_dec;
					front_n = front_dec;
					count_n = count_q + CW'(1);
				end
			end
			deq_pkg::OP_POP_BACK, deq_pkg::OP_PEEK_BACK: begin
				if (is_empty) begin
					status_n = deq_pkg::ST_EMPTY;
				end else begin
					re       = 1'b1;
					rd_sel_n = 1'b1;
					addr     = back_slot;
					if (op_q == deq_pkg::OP_POP_BACK) begin
						count_n = count_q - CW'(1);
					end
				end
			end
			deq_pkg::OP_POP_FRONT, deq_pkg::OP_PEEK_FRONT: begin
				if (is_empty) begin
					status_n = deq_pkg::ST_EMPTY;
				end else begin
					re       = 1'b1;
					rd_sel_n = 1'b1;
					addr     = front_q;
					if (op_q == deq_pkg::OP_POP_FRONT) begin
						front_n = front_inc;
						count_n = count_q - CW'(1);
					end
				end
			end
			deq_pkg::OP_WRITE_BACK: begin
				if (is_empty) begin
					status_n = deq_pkg::ST_EMPTY;
				end else begin
					we   = 1'b1;
					addr = back_slot;
				end
			end
			deq_pkg::OP_WRITE_FRONT: begin
				if (is_empty) begin
					status_n = deq_pkg::ST_EMPTY;
				end else begin
					we   = 1'b1;
					addr = front_q;
				end
			end
			deq_pkg::OP_CLEAR: begin
				front_n = '0;
				count_n = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= opcode;
			value_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			count_q  <= '0;
			status_q <= deq_pkg::ST_OK;
			rd_sel_q <= 1'b0;
		end else if (cmd.exec) begin
			front_q  <= front_n;
			count_q  <= count_n;
			status_q <= status_n;
			rd_sel_q <= rd_sel_n;
		end
	end

	deq_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (cmd.exec && we),
		.waddr(addr),
		.wdata(value_q),
		.re   (cmd.exec && re),
		.raddr(addr),
		.rdata(rdata)
	);

	assign data   = rd_sel_q ? rdata : '0;
	assign status = status_q;
	assign count  = count_q;

	`DEQ_ASSERT(a_count_range, count_q <= FULL_COUNT, "word count above depth")
	`DEQ_ASSERT(a_front_range, front_q <= LAST_SLOT, "front pointer outside memory")
	`DEQ_ASSERT(a_hold_idle, !cmd.exec |=> ($stable(count_q) && $stable(front_q)), "pointers moved without execute")

endmodule

`default_nettype wire

/* hw/rtl/double_ended_queue.sv */
// Top level of the double-ended queue: controller plus datapath.
// Depends on deq_pkg, deq_ctrl, deq_datapath and deq_ram.
`timescale 1ns / 1ps
`default_nettype none

// Double-ended queue of DATA_WIDTH-bit words in a circular buffer of DEPTH
// slots. A transfer is taken on a rising edge with start high and busy low.
// Its result appears after the execute state, with done high for one
// cycle only, and the receiver cannot stall it, so data, status and count
// must be captured when done is high. Each operation has an execute state
// for the single slot-memory access and a result state to show the result,
// during which the next transfer can already be taken. The slot memory is
// not cleared at reset; only live words are ever read.
module double_ended_queue #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [3:0]                   opcode,
	input  wire logic signed [DATA_WIDTH-1:0] value,
	output logic                              done,
	output logic signed [DATA_WIDTH-1:0]      data,
	output logic [1:0]                        status,
	output logic [$clog2(DEPTH+1)-1:0]        count
);

	deq_pkg::deq_cmd_t cmd;

	deq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd)
	);

	deq_datapath #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.opcode(opcode),
		.value (value),
		.data  (data),
		.status(status),
		.count (count)
	);

endmodule

`default_nettype wire
